// ----- rtl/tmu_pkg.sv -----
// Shared types and constants for the tagged memory unit.
`timescale 1ns / 1ps
`default_nettype none

package tmu_pkg;

  // Command codes
  typedef enum logic [2:0] {
    CMD_FETCH = 3'd0,
    CMD_SETIC = 3'd1,
    CMD_LDW   = 3'd2,
    CMD_STW   = 3'd3,
    CMD_LDB   = 3'd4,
    CMD_STB   = 3'd5,
    CMD_PREW  = 3'd6,
    CMD_PREB  = 3'd7
  } cmd_e;

  // Error codes
  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_RANGE     = 3'd1,
    ERR_ALIGN     = 3'd2,
    ERR_NOTINSTR  = 3'd3,
    ERR_OVERWRITE = 3'd4
  } err_e;

  // Content tags
  localparam logic [1:0] TAG_UNDEF = 2'b00;
  localparam logic [1:0] TAG_FMT_A = 2'b01;
  localparam logic [1:0] TAG_FMT_B = 2'b10;
  localparam logic [1:0] TAG_DATA  = 2'b11;

  // Cycle costs and counter step
  localparam logic [31:0] HIT_COST  = 32'd1;
  localparam logic [31:0] MISS_COST = 32'd10;
  localparam logic [31:0] IC_STEP   = 32'd4;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_ACCESS = 2'd2
  } state_e;

endpackage

`default_nettype wire

// ----- rtl/tagged_memory_unit.sv -----
// Tagged word store with instruction counter, one-word hit buffer and cycle count.
// The store is read and the command captured at the input transfer; in ST_ACCESS the
// result is then registered and out_valid_o rises (held back only while a previous
// result is still stalled). in_stall_o stays high in ST_ACCESS, so a new command is
// taken only after the current one is done and the sequencer is back in ST_IDLE.
// Reset: control state clears at once; then a clearing pass writes zero to all
// WORDS entries, one per cycle, before the first command is taken.
`timescale 1ns / 1ps
`default_nettype none

module tagged_memory_unit #(
  parameter int unsigned WORDS = 1024
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  tmu_pkg::cmd_e        command_i,
  input  wire signed [31:0]    address_i,
  input  wire signed [31:0]    write_data_i,
  input  wire        [1:0]     tag_in_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic signed [31:0]   read_data_o,
  output logic        [1:0]    tag_out_o,
  output logic        [2:0]    error_code_o,
  output logic signed [31:0]   counter_now_o,
  output logic        [31:0]   cycle_total_o
);
  import tmu_pkg::*;

  localparam int unsigned IDX_W = $clog2(WORDS);
  localparam logic [29:0] WORDS_W = 30'(WORDS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORDS - 1);

  // Sequencer
  state_e state_q, state_d;
  logic [IDX_W-1:0] clr_q, clr_d;
  logic in_xfer, done;

  // Captured command
  cmd_e        cmd_q;
  logic [31:0] addr_q, wdata_q;
  logic [1:0]  tag_in_q;

  // Architectural registers
  logic [31:0]      ic_q, ic_d;
  logic [31:0]      cyc_q, cyc_d;
  logic             lwi_vld_q, lwi_vld_d;
  logic [IDX_W-1:0] lwi_q, lwi_d;
  logic [31:0]      lwd_q, lwd_d;

  // Store: {tag, word}
  logic [33:0]      mem [WORDS];
  logic [33:0]      mem_rdata_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [33:0]      mem_wdata;

  // Result
  logic        out_valid_q;
  logic [31:0] rd_q, ic_out_q, cyc_out_q;
  logic [1:0]  tout_q;
  logic [2:0]  err_q;

  // Datapath intermediates
  logic [31:0]      rd_d;
  logic [1:0]       tout_d;
  err_e             err_d;
  logic             wr_en;
  logic [33:0]      wr_data;
  logic [31:0]      mem_word, merged;
  logic [1:0]       mem_tag;
  logic [IDX_W-1:0] idx;
  logic             addr_oor, ic_oor, hit, tag_instr;

  assign in_xfer = in_valid_i && !in_stall_o;

  // Next state
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        if (done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = 1'b1;
    done       = 1'b0;
    case (state_q)
      ST_CLEAR:  in_stall_o = 1'b1;
      ST_IDLE:   in_stall_o = 1'b0;
      ST_ACCESS: done = !(out_valid_q && out_stall_i);
      default:   in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // Command capture
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q    <= command_i;
      addr_q   <= address_i;
      wdata_q  <= write_data_i;
      tag_in_q <= tag_in_i;
    end
  end

  // Checks on the captured command and the read word
  assign mem_word  = mem_rdata_q[31:0];
  assign mem_tag   = mem_rdata_q[33:32];
  assign idx       = addr_q[IDX_W+1:2];
  assign addr_oor  = addr_q[31] || (addr_q[31:2] >= WORDS_W);
  assign ic_oor    = ic_q[31] || (ic_q[31:2] >= WORDS_W);
  assign hit       = lwi_vld_q && (lwi_q == idx);
  assign tag_instr = (mem_tag == TAG_FMT_A) || (mem_tag == TAG_FMT_B);

  // Byte merge, little-endian lanes
  always_comb begin
    merged = mem_word;
    for (int b = 0; b < 4; b++) begin
      if (addr_q[1:0] == 2'(b)) begin
        merged[b*8 +: 8] = wdata_q[7:0];
      end
    end
  end

  // Command execution
  always_comb begin
    rd_d      = '0;
    tout_d    = TAG_UNDEF;
    err_d     = ERR_OK;
    ic_d      = ic_q;
    cyc_d     = cyc_q;
    lwi_vld_d = lwi_vld_q;
    lwi_d     = lwi_q;
    lwd_d     = lwd_q;
    wr_en     = 1'b0;
    wr_data   = mem_rdata_q;
    if (cmd_q == CMD_FETCH) begin
      if (ic_oor) begin
        err_d = ERR_RANGE;
      end else if (!tag_instr) begin
        err_d = ERR_NOTINSTR;
      end else begin
        rd_d   = mem_word;
        tout_d = mem_tag;
        ic_d   = ic_q + IC_STEP;
        cyc_d  = cyc_q + MISS_COST;
      end
    end else if (cmd_q == CMD_SETIC) begin
      ic_d = addr_q;
    end else if (addr_oor) begin
      err_d = ERR_RANGE;
    end else if ((cmd_q == CMD_LDW || cmd_q == CMD_STW || cmd_q == CMD_PREW)
                 && addr_q[1:0] != 2'b00) begin
      err_d = ERR_ALIGN;
    end else begin
      case (cmd_q)
        CMD_LDW: begin
          if (hit) begin
            cyc_d = cyc_q + HIT_COST;
            rd_d  = lwd_q;
          end else begin
            lwi_vld_d = 1'b1;
            lwi_d     = idx;
            lwd_d     = mem_word;
            cyc_d     = cyc_q + MISS_COST;
            rd_d      = mem_word;
          end
        end
        CMD_LDB: begin
          if (hit) begin
            cyc_d = cyc_q + HIT_COST;
          end else begin
            lwi_vld_d = 1'b1;
            lwi_d     = idx;
            cyc_d     = cyc_q + MISS_COST;
          end
          lwd_d = mem_word;
          rd_d  = {24'd0, mem_word[{addr_q[1:0], 3'b000} +: 8]};
        end
        CMD_STW: begin
          if (tag_instr) begin
            err_d = ERR_OVERWRITE;
          end else begin
            lwi_vld_d = 1'b1;
            lwi_d     = idx;
            lwd_d     = wdata_q;
            cyc_d     = cyc_q + MISS_COST;
            wr_en     = 1'b1;
            wr_data   = {TAG_DATA, wdata_q};
          end
        end
        CMD_STB: begin
          if (tag_instr) begin
            err_d = ERR_OVERWRITE;
          end else begin
            wr_en   = 1'b1;
            wr_data = {TAG_DATA, merged};
          end
        end
        CMD_PREW: begin
          wr_en   = 1'b1;
          wr_data = {tag_in_q, wdata_q};
        end
        CMD_PREB: begin
          wr_en   = 1'b1;
          wr_data = {tag_in_q, merged};
        end
        default: err_d = ERR_OK;
      endcase
    end
  end

  // Store port control: clearing sweep or write-back
  assign mem_raddr = (command_i == CMD_FETCH) ? ic_q[IDX_W+1:2] : address_i[IDX_W+1:2];
  always_comb begin
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = done && wr_en;
      mem_waddr = idx;
      mem_wdata = wr_data;
    end
  end

  // Tag/word store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_xfer) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  // Counter, cycle count, hit buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q      <= '1;
      cyc_q     <= '0;
      lwi_vld_q <= 1'b0;
      lwi_q     <= '0;
      lwd_q     <= '0;
    end else if (done) begin
      ic_q      <= ic_d;
      cyc_q     <= cyc_d;
      lwi_vld_q <= lwi_vld_d;
      lwi_q     <= lwi_d;
      lwd_q     <= lwd_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      rd_q      <= rd_d;
      tout_q    <= tout_d;
      err_q     <= err_d;
      ic_out_q  <= ic_d;
      cyc_out_q <= cyc_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = rd_q;
  assign tag_out_o     = tout_q;
  assign error_code_o  = err_q;
  assign counter_now_o = ic_out_q;
  assign cycle_total_o = cyc_out_q;

endmodule

`default_nettype wire

// ----- tb/tagged_memory_unit_checker.sv -----
// Checker for the tagged memory unit: predicts each result and compares the output transfers.
`timescale 1ns / 1ps

module tagged_memory_unit_checker #(
  parameter int unsigned WORDS = 1024
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  input  wire                in_stall_i,
  input  tmu_pkg::cmd_e      command_i,
  input  wire        [31:0]  address_i,
  input  wire        [31:0]  write_data_i,
  input  wire        [1:0]   tag_in_i,
  input  wire                out_valid_i,
  input  wire                out_stall_i,
  input  wire        [31:0]  read_data_i,
  input  wire        [1:0]   tag_out_i,
  input  wire        [2:0]   error_code_i,
  input  wire        [31:0]  counter_now_i,
  input  wire        [31:0]  cycle_total_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 compared_o,
  output int                 hits_o
);
  import tmu_pkg::*;

  localparam logic [31:0] BYTE_MASK = 32'h0000_00FF;

  typedef struct {
    logic [31:0] read_data;
    logic [1:0]  tag_out;
    err_e        error_code;
    logic [31:0] counter_now;
    logic [31:0] cycle_total;
  } mem_result_t;

  // Predicted copy of the unit's state
  logic [31:0] word_mem [WORDS];
  logic [1:0]  tag_mem  [WORDS];
  logic [31:0] icount;
  logic [31:0] ireg;
  logic [31:0] buf_idx;
  logic [31:0] buf_data;
  logic [31:0] cycles;

  mem_result_t result_q [$];
  int fails = 0;
  int compared = 0;
  int hits = 0;
  int pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;
  assign compared_o   = compared;
  assign hits_o       = hits;

  function automatic bit addr_out_of_range(input logic [31:0] a);
    return a[31] || ({2'b00, a[31:2]} >= WORDS);
  endfunction

  function automatic bit holds_instr(input logic [1:0] t);
    return (t == TAG_FMT_A) || (t == TAG_FMT_B);
  endfunction

  // Replace one little-endian byte of a word
  function automatic logic [31:0] merge_byte(input logic [31:0] w, input logic [1:0] off,
                                             input logic [31:0] b);
    return (w & ~(BYTE_MASK << {off, 3'b000})) | ((b & BYTE_MASK) << {off, 3'b000});
  endfunction

  // Apply one command to the predicted state and queue its result
  task automatic predict_command(input cmd_e cmd, input logic [31:0] addr,
                                 input logic [31:0] wdata, input logic [1:0] tagin);
    mem_result_t r;
    logic [31:0] idx;
    logic [1:0]  off;
    r.read_data  = '0;
    r.tag_out    = TAG_UNDEF;
    r.error_code = ERR_OK;
    idx = {2'b00, addr[31:2]};
    off = addr[1:0];
    case (cmd)
      CMD_FETCH: begin
        // fetch ignores the low counter bits
        if (addr_out_of_range(icount)) begin
          ireg = '0;
          r.error_code = ERR_RANGE;
        end else if (!holds_instr(tag_mem[icount[31:2]])) begin
          r.error_code = ERR_NOTINSTR;
        end else begin
          ireg        = word_mem[icount[31:2]];
          r.read_data = ireg;
          r.tag_out   = tag_mem[icount[31:2]];
          icount      = icount + IC_STEP;
          cycles      = cycles + MISS_COST;
        end
      end
      CMD_SETIC: icount = addr;
      default: begin
        if (addr_out_of_range(addr)) begin
          r.error_code = ERR_RANGE;
        end else if ((cmd inside {CMD_LDW, CMD_STW, CMD_PREW}) && off != 2'b00) begin
          r.error_code = ERR_ALIGN;
        end else begin
          case (cmd)
            CMD_LDW, CMD_LDB: begin
              if (idx == buf_idx) begin
                cycles = cycles + HIT_COST;
                hits++;
              end else begin
                buf_idx = idx;
                cycles  = cycles + MISS_COST;
                if (cmd == CMD_LDW) buf_data = word_mem[idx];
              end
              // byte loads always refill; word hits may return stale data
              if (cmd == CMD_LDB) begin
                buf_data    = word_mem[idx];
                r.read_data = (buf_data >> {off, 3'b000}) & BYTE_MASK;
              end else begin
                r.read_data = buf_data;
              end
            end
            CMD_STW, CMD_STB: begin
              if (holds_instr(tag_mem[idx])) begin
                r.error_code = ERR_OVERWRITE;
              end else if (cmd == CMD_STW) begin
                buf_data      = wdata;
                buf_idx       = idx;
                word_mem[idx] = wdata;
                tag_mem[idx]  = TAG_DATA;
                cycles        = cycles + MISS_COST;
              end else begin
                word_mem[idx] = merge_byte(word_mem[idx], off, wdata);
                tag_mem[idx]  = TAG_DATA;
              end
            end
            CMD_PREW: begin
              word_mem[idx] = wdata;
              tag_mem[idx]  = tagin;
            end
            default: begin
              word_mem[idx] = merge_byte(word_mem[idx], off, wdata);
              tag_mem[idx]  = tagin;
            end
          endcase
        end
      end
    endcase
    r.counter_now = icount;
    r.cycle_total = cycles;
    result_q.push_back(r);
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", field, want, got);
      fails++;
    end
  endtask

  task automatic compare_result();
    mem_result_t want;
    if (result_q.size() == 0) begin
      $error("result transfer with no command pending");
      fails++;
    end else begin
      want = result_q.pop_front();
      compared++;
      check_field("read_data", want.read_data, read_data_i);
      check_field("tag_out", 32'(want.tag_out), 32'(tag_out_i));
      check_field("error_code", 32'(want.error_code), 32'(error_code_i));
      check_field("counter_now", want.counter_now, counter_now_i);
      check_field("cycle_total", want.cycle_total, cycle_total_i);
    end
  endtask

  // Predict on each input transfer, compare on each output transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WORDS; i++) begin
        word_mem[i] = '0;
        tag_mem[i]  = TAG_UNDEF;
      end
      icount   = '1;
      ireg     = '0;
      buf_idx  = '1;
      buf_data = '0;
      cycles   = '0;
      result_q.delete();
      pending <= 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        predict_command(command_i, address_i, write_data_i, tag_in_i);
      if (out_valid_i && !out_stall_i) compare_result();
      pending <= result_q.size();
    end
  end

endmodule

// ----- tb/tagged_memory_unit_tb.sv -----
// Testbench top for the tagged memory unit: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tagged_memory_unit_tb;
  import tmu_pkg::*;

  localparam int unsigned WORDS = 1024;
  localparam int N_ITEMS      = 1850;
  localparam int MAX_IDLE     = 8;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam logic [31:0] TOP_WORD = (WORDS - 1) * 4;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  cmd_e        command    = CMD_FETCH;
  logic [31:0] address    = '0;
  logic [31:0] write_data = '0;
  logic [1:0]  tag_in     = TAG_UNDEF;
  logic        out_stall  = 1'b0;

  wire         in_stall;
  wire         out_valid;
  wire  [31:0] read_data;
  wire  [1:0]  tag_out;
  wire  [2:0]  error_code;
  wire  [31:0] counter_now;
  wire  [31:0] cycle_total;

  int fail_count;
  int pending;
  int compared;
  int hits;
  int sent       = 0;
  int run_cycles = 0;
  bit quiet      = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  tagged_memory_unit #(.WORDS(WORDS)) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .command_i     (command),
    .address_i     (address),
    .write_data_i  (write_data),
    .tag_in_i      (tag_in),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .read_data_o   (read_data),
    .tag_out_o     (tag_out),
    .error_code_o  (error_code),
    .counter_now_o (counter_now),
    .cycle_total_o (cycle_total)
  );

  tagged_memory_unit_checker #(.WORDS(WORDS)) scoreboard (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .command_i     (command),
    .address_i     (address),
    .write_data_i  (write_data),
    .tag_in_i      (tag_in),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .read_data_i   (read_data),
    .tag_out_i     (tag_out),
    .error_code_i  (error_code),
    .counter_now_i (counter_now),
    .cycle_total_i (cycle_total),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .compared_o    (compared),
    .hits_o        (hits)
  );

  // Wait count for one transfer; zero during quiet stretches
  function automatic int idle_cycles();
    return quiet ? 0 : $urandom_range(MAX_IDLE, 0);
  endfunction

  function automatic logic [1:0] rand_tag();
    return 2'($urandom_range(3));
  endfunction

  // Mostly a small window of words, plus the top end, just past the end and negatives
  function automatic logic [31:0] pick_address();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return ($urandom_range(63) << 2) | $urandom_range(3);
    if (r < 70) return ($urandom_range(WORDS - 1, WORDS - 8) << 2) | $urandom_range(3);
    if (r < 80) return $urandom();
    if (r < 85) return ((WORDS + $urandom_range(15)) << 2) | $urandom_range(3);
    if (r < 90) return $urandom() & 32'h7FFF_FFFF;
    return $urandom() | 32'h8000_0000;
  endfunction

  // One input transfer, with a random gap in front of it
  task automatic send_command(input cmd_e cmd, input logic [31:0] addr,
                              input logic [31:0] wdata, input logic [1:0] tag);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    address    <= addr;
    write_data <= wdata;
    tag_in     <= tag;
    do @(posedge clk); while (in_stall);
    sent++;
    if (sent % 97 == 0) quiet = ($urandom_range(3) == 0);
  endtask

  task automatic random_command();
    cmd_e        cmd;
    logic [31:0] addr;
    cmd  = cmd_e'($urandom_range(7));
    addr = pick_address();
    if ((cmd inside {CMD_LDW, CMD_STW, CMD_PREW, CMD_SETIC}) && $urandom_range(3) != 0)
      addr[1:0] = 2'b00;
    send_command(cmd, addr, $urandom(), rand_tag());
  endtask

  // Preload a short instruction stream, point the counter at it and fetch through
  task automatic run_program();
    int          len;
    logic [31:0] base;
    logic [1:0]  tag;
    len  = $urandom_range(6, 1);
    base = $urandom_range(57) << 2;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(5) == 0) tag = rand_tag();
      else tag = $urandom_range(1) ? TAG_FMT_A : TAG_FMT_B;
      if ($urandom_range(4) == 0)
        send_command(CMD_PREB, base + 4 * i + $urandom_range(3), $urandom(), tag);
      else
        send_command(CMD_PREW, base + 4 * i, $urandom(), tag);
    end
    send_command(CMD_SETIC, ($urandom_range(3) == 0) ? (base | $urandom_range(3)) : base,
                 $urandom(), rand_tag());
    for (int i = 0; i <= len; i++) begin
      if ($urandom_range(7) == 0) random_command();
      else send_command(CMD_FETCH, pick_address(), $urandom(), rand_tag());
    end
  endtask

  // Mixed stores and loads on one word to work the hit buffer
  task automatic run_data_burst();
    logic [31:0] burst_base;
    burst_base = ($urandom_range(1) ? $urandom_range(63) : $urandom_range(WORDS - 1, WORDS - 8))
                 << 2;
    repeat ($urandom_range(6, 2)) begin
      case ($urandom_range(4))
        0: send_command(CMD_STW, burst_base, $urandom(), rand_tag());
        1: send_command(CMD_STB, burst_base | $urandom_range(3), $urandom(), rand_tag());
        2: send_command(CMD_LDW, burst_base, $urandom(), rand_tag());
        3: send_command(CMD_LDB, burst_base | $urandom_range(3), $urandom(), rand_tag());
        default: send_command(CMD_PREB, burst_base | $urandom_range(3), $urandom(), rand_tag());
      endcase
    end
  endtask

  // Result side: random stall ahead of each output transfer
  initial begin
    int n;
    @(posedge clk);
    forever begin
      n = idle_cycles();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Run limit
  initial begin
    while (run_cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      run_cycles++;
    end
    $error("no completion after %0d cycles", CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    int r;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: counter at reset, fetch of undefined and instruction words
    send_command(CMD_FETCH, 32'h0, 32'h0, TAG_UNDEF);
    send_command(CMD_SETIC, 32'h0, 32'h0, TAG_UNDEF);
    send_command(CMD_FETCH, 32'h0, 32'h0, TAG_UNDEF);
    send_command(CMD_PREW, 32'h0, 32'hFFFF_FFFF, TAG_FMT_A);
    send_command(CMD_PREB, 32'h5, 32'h0000_00A5, TAG_FMT_B);
    send_command(CMD_FETCH, 32'h0, 32'h0, TAG_UNDEF);
    send_command(CMD_FETCH, 32'h0, 32'h0, TAG_UNDEF);
    send_command(CMD_FETCH, 32'h0, 32'h0, TAG_UNDEF);
    // overwrite protection, range and alignment errors
    send_command(CMD_STW, 32'h0, 32'h1234_5678, TAG_DATA);
    send_command(CMD_STB, 32'h7, 32'h0000_00FF, TAG_DATA);
    send_command(CMD_LDW, 32'h8000_0000, 32'h0, TAG_UNDEF);
    send_command(CMD_LDB, WORDS * 4, 32'h0, TAG_UNDEF);
    send_command(CMD_LDW, 32'h1, 32'h0, TAG_UNDEF);
    send_command(CMD_PREW, 32'h2, 32'h0, TAG_DATA);
    send_command(CMD_PREB, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TAG_DATA);
    // top word: hit buffer, stale word after a byte store, byte refill
    send_command(CMD_STW, TOP_WORD, 32'hFFFF_FFFF, TAG_UNDEF);
    send_command(CMD_LDW, TOP_WORD, 32'h0, TAG_UNDEF);
    send_command(CMD_STB, TOP_WORD + 3, 32'h0000_0000, TAG_UNDEF);
    send_command(CMD_LDW, TOP_WORD, 32'h0, TAG_UNDEF);
    send_command(CMD_LDB, TOP_WORD + 3, 32'h0, TAG_UNDEF);
    send_command(CMD_LDW, TOP_WORD, 32'h0, TAG_UNDEF);
    send_command(CMD_LDB, 32'h5, 32'h0, TAG_UNDEF);
    // counter out of range, and running off the end of the store
    send_command(CMD_SETIC, 32'h7FFF_FFFC, 32'h0, TAG_UNDEF);
    send_command(CMD_FETCH, 32'h0, 32'h0, TAG_UNDEF);
    send_command(CMD_PREW, TOP_WORD, 32'h8000_0000, TAG_FMT_A);
    send_command(CMD_SETIC, TOP_WORD, 32'h0, TAG_UNDEF);
    send_command(CMD_FETCH, 32'h0, 32'h0, TAG_UNDEF);
    send_command(CMD_FETCH, 32'h0, 32'h0, TAG_UNDEF);

    // Random: mostly structured bursts, the rest single noise commands
    while (sent < N_ITEMS) begin
      r = $urandom_range(99);
      if (r < 15) run_program();
      else if (r < 40) run_data_burst();
      else random_command();
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d commands sent, %0d results compared, %0d loads hit the buffer",
             sent, compared, hits);
    $display("Covered fetch streams, hit-buffer reuse, overwrite, range and alignment errors");
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- tagged_memory_unit.f -----
rtl/tmu_pkg.sv
rtl/tagged_memory_unit.sv
tb/tagged_memory_unit_checker.sv
tb/tagged_memory_unit_tb.sv
